FILE: hdl/ucbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_pkg
// Shared types, codes and constants of the UCB child selector.
// ----------------------------------------------------------------------------
package ucbcs_pkg;

    localparam int MAX_CHILDREN_DEF = 256;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int CW        = 24;  // explore weight width
    localparam int SCORE_W   = 48;
    localparam int DIV_W     = 64;  // dividend and quotient width
    localparam int DIVISOR_W = 32;
    localparam int SQ_V_W    = 50;  // root operand width
    localparam int LOG_X_W   = 33;  // parent visits plus one
    localparam int IDX_W     = 8;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_SCORE_MODE     = 2'd0;
    localparam cfg_index_t CFG_EXPLORE_WEIGHT = 2'd1;
    localparam cfg_index_t CFG_VARIANCE_BIAS  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK           = 2'd0;
    localparam status_t STATUS_NOT_EXPANDED = 2'd1;
    localparam status_t STATUS_NO_WINNER    = 2'd2;

    typedef struct packed {
        logic [31:0]        parent_visits;
        logic               parent_expanded;
        logic [31:0]        child_visits;
        logic signed [31:0] child_reward;
        logic [47:0]        child_sq_reward;
        logic               last_child;
    } child_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]          best_index;
        logic signed [SCORE_W-1:0] win_score;
        status_t                   status;
    } select_rsp_t;

    typedef struct packed {
        cfg_index_t  index;
        logic [31:0] wdata;
    } cfg_req_t;

    typedef struct packed {
        logic                 start;
        logic                 wide;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ,
        LG_MUL
    } log_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MEAN,
        S_TDIV,
        S_TSQRT,
        S_QSTART,
        S_QDIV,
        S_RAD,
        S_RDIV,
        S_RSQRT,
        S_SUM,
        S_UPDATE,
        S_FINISH
    } seq_state_t;

endpackage

FILE: hdl/ucbcs_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface ucbcs_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ucbcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_div
// Bit-serial restoring divider, one quotient bit per cycle, 32 or 64 steps.
// ----------------------------------------------------------------------------
module ucbcs_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ucbcs_pkg::div_req_t                    req,
    output logic                                   busy,
    output logic [ucbcs_pkg::DIV_W-1:0]            quot
);
    import ucbcs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] diff;
    logic                 ge;

    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};
    assign ge      = ~diff[DIVISOR_W+1];

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            // narrow requests sit in the upper half so the same shift path serves
            q_next   = req.wide ? req.dividend
                                : {req.dividend[DIV_W/2-1:0], {(DIV_W/2){1'b0}}};
            rem_next = '0;
            d_next   = req.divisor;
            cnt_next = req.wide ? CNT_W'(DIV_W) : CNT_W'(DIV_W / 2);
        end
        else if (cnt_reg != '0)
        begin
            q_next   = {q_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            rem_reg <= '0;
            d_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

FILE: hdl/ucbcs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_sqrt
// Digit-by-digit square root of v * 2^FRAC_BITS, one root bit per cycle.
// ----------------------------------------------------------------------------
module ucbcs_sqrt #(
    parameter int FRAC_BITS = ucbcs_pkg::FRAC_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [ucbcs_pkg::SQ_V_W-1:0]                      v,
    output logic                                              busy,
    output logic [(ucbcs_pkg::SQ_V_W+FRAC_BITS+1)/2-1:0]      root
);
    import ucbcs_pkg::*;

    localparam int PAIRS = (SQ_V_W + FRAC_BITS + 1) / 2;
    localparam int XW    = 2 * PAIRS;
    localparam int RW    = PAIRS + 3;
    localparam int CNT_W = $clog2(PAIRS + 1);

    logic [XW-1:0]    x_reg, x_next;
    logic [PAIRS-1:0] root_reg, root_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    shifted, trial;
    logic             ge;

    assign shifted = {rem_reg[RW-3:0], x_reg[XW-1:XW-2]};
    assign trial   = RW'({root_reg, 2'b01});
    assign ge      = (shifted >= trial);

    always_comb
    begin
        x_next    = x_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            x_next    = XW'({v, {FRAC_BITS{1'b0}}});
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(PAIRS);
        end
        else if (cnt_reg != '0)
        begin
            x_next    = {x_reg[XW-3:0], 2'b00};
            root_next = {root_reg[PAIRS-2:0], ge};
            rem_next  = ge ? (shifted - trial) : shifted;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

FILE: hdl/ucbcs_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_log
// Natural log of x in fixed point: serial normalise, repeated squaring for
// the fraction of log2, then one scaling multiply by ln 2.
// ----------------------------------------------------------------------------
module ucbcs_log #(
    parameter int FRAC_BITS = ucbcs_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ucbcs_pkg::LOG_X_W-1:0]     x,
    output logic                              busy,
    output logic [FRAC_BITS+5:0]              ln
);
    import ucbcs_pkg::*;

    localparam int LW    = FRAC_BITS + 6;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int MW    = 31;

    log_state_t         state_reg, state_next;
    logic [LOG_X_W-1:0] xs_reg, xs_next;
    logic [5:0]         k_reg, k_next;
    logic [MW-1:0]      m_reg, m_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]      ln_reg, ln_next;
    logic [2*MW-1:0]    sq_prod;
    logic [31:0]        sq_top;
    logic [LW+31:0]     ln_prod;

    assign sq_prod = (2*MW)'(m_reg) * (2*MW)'(m_reg);
    assign sq_top  = sq_prod[2*MW-1:30];
    assign ln_prod = (LW+32)'({k_reg, frac_reg}) * (LW+32)'(LN2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            xs_reg    <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            ln_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            xs_reg    <= xs_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            ln_reg    <= ln_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        xs_next    = xs_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        ln_next    = ln_reg;
        unique case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    xs_next    = x;
                    k_next     = 6'(LOG_X_W - 1);
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                // shift until the leading one reaches the top; mantissa is Q1.30
                if (xs_reg[LOG_X_W-1])
                begin
                    m_next     = xs_reg[LOG_X_W-1:2];
                    frac_next  = '0;
                    cnt_next   = CNT_W'(FRAC_BITS);
                    state_next = LG_SQ;
                end
                else
                begin
                    xs_next = {xs_reg[LOG_X_W-2:0], 1'b0};
                    k_next  = k_reg - 1'b1;
                end
            end
            LG_SQ:
            begin
                if (sq_top[31])
                begin
                    m_next    = sq_top[31:1];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_top[MW-1:0];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = LG_MUL;
            end
            LG_MUL:
            begin
                ln_next    = ln_prod[LW+31:32];
                state_next = LG_IDLE;
            end
            default:
                state_next = LG_IDLE;
        endcase
    end

    assign busy = (state_reg != LG_IDLE);
    assign ln   = ln_reg;

endmodule

FILE: hdl/ucb_child_selector.sv
`timescale 1ns / 1ps
// Children are scored one at a time, in UCB1 or SP-UCT mode, paced by the serial
// log, the bit-serial divider (32 or 64 steps) and the one-bit-a-cycle root unit;
// a child with zero visits skips the serial units.
// Reset: asynchronous, active low; clears the node state and restores the
// configuration registers to their reset values. No clearing pass.
// ----------------------------------------------------------------------------
// ucb_child_selector
// Scores the children of a search node and reports the best one.
// ----------------------------------------------------------------------------
module ucb_child_selector #(
    parameter int MAX_CHILDREN = ucbcs_pkg::MAX_CHILDREN_DEF,
    parameter int FRAC_BITS    = ucbcs_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ucbcs_chan_if.sink    in_chan,
    ucbcs_chan_if.source  out_chan,
    ucbcs_chan_if.sink    cfg_chan
);
    import ucbcs_pkg::*;

    localparam int POS_W   = $clog2(MAX_CHILDREN + 1);
    localparam int LW      = FRAC_BITS + 6;
    localparam int PAIRS   = (SQ_V_W + FRAC_BITS + 1) / 2;
    localparam int RT_W    = FRAC_BITS + 4;   // bits of the exploration root
    localparam int EXP_PW  = CW + RT_W;
    localparam int EXP_W   = EXP_PW - FRAC_BITS;
    localparam int SUM_W   = SCORE_W + 2;

    seq_state_t state_reg, state_next;

    // configuration
    logic          score_mode_reg;
    logic [CW-1:0] explore_weight_reg;
    logic [31:0]   variance_bias_reg;

    // node state
    logic [POS_W-1:0]          pos_reg;
    logic signed [SCORE_W-1:0] win_score_reg;
    logic [IDX_W-1:0]          best_index_reg;
    logic                      have_winner_reg;
    logic                      expand_err_reg;

    // per-child working registers
    child_req_t                item_reg;
    logic [IDX_W-1:0]          cur_idx_reg;
    logic signed [32:0]        mean_reg;
    logic [EXP_W-1:0]          explore_reg;
    logic [PAIRS-1:0]          var_reg;
    logic [63:0]               sqr_reg;
    logic [SQ_V_W-1:0]         rad_reg;
    logic                      rad_neg_reg;
    logic signed [SCORE_W-1:0] score_reg;

    select_rsp_t rsp_reg;
    logic        out_valid_reg;

    // serial units
    div_req_t          div_req;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quot;
    logic              log_start, log_busy;
    logic [LW-1:0]     ln_val;
    logic              sqrt_start, sqrt_busy;
    logic [SQ_V_W-1:0] sqrt_v;
    logic [PAIRS-1:0]  sqrt_root;

    logic              in_fire, slot_free, emit;
    logic              r_neg;
    logic [31:0]       abs_r;
    logic [EXP_PW-1:0] expl_prod;
    logic [48:0]       sq_sum;
    logic [63:0]       q_shift;
    logic signed [64:0] rad;
    logic signed [SUM_W-1:0] sum;
    logic signed [SCORE_W-1:0] sum_sat;

    assign in_fire   = in_chan.valid && in_chan.ready;
    assign slot_free = !out_valid_reg || out_chan.ready;

    assign r_neg     = item_reg.child_reward[31];
    assign abs_r     = r_neg ? (32'd0 - item_reg.child_reward) : item_reg.child_reward;
    assign expl_prod = EXP_PW'(explore_weight_reg) * EXP_PW'(sqrt_root[RT_W-1:0]);
    assign sq_sum    = 49'(item_reg.child_sq_reward) + 49'(variance_bias_reg);
    assign q_shift   = div_quot >> FRAC_BITS;
    assign rad       = $signed({16'b0, sq_sum}) - $signed({1'b0, q_shift});
    assign sum       = SUM_W'(mean_reg) + $signed(SUM_W'(explore_reg))
                       + $signed(SUM_W'(var_reg));

    always_comb
    begin
        if (sum > SUM_W'(SCORE_MAX))
            sum_sat = SCORE_MAX;
        else if (sum < SUM_W'(SCORE_MIN))
            sum_sat = SCORE_MIN;
        else
            sum_sat = sum[SCORE_W-1:0];
    end

    ucbcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    ucbcs_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .x     (LOG_X_W'(item_reg.parent_visits) + 1'b1),
        .busy  (log_busy),
        .ln    (ln_val)
    );

    ucbcs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .v     (sqrt_v),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.wide     = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = item_reg.child_visits;
        log_start        = 1'b0;
        sqrt_start       = 1'b0;
        sqrt_v           = '0;
        emit             = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pos_reg >= POS_W'(MAX_CHILDREN))
                    state_next = S_FINISH;
                else if (item_reg.child_visits == '0)
                    state_next = S_UPDATE;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(abs_r);
                    log_start        = 1'b1;
                    state_next       = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (!div_busy && !log_busy)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({ln_val, 1'b0});
                    state_next       = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (!div_busy)
                begin
                    sqrt_start = 1'b1;
                    sqrt_v     = SQ_V_W'(div_quot[31:0]);
                    state_next = score_mode_reg ? S_QSTART : S_TSQRT;
                end
            end
            S_TSQRT:
            begin
                if (!sqrt_busy)
                    state_next = S_SUM;
            end
            S_QSTART:
            begin
                div_req.start    = 1'b1;
                div_req.wide     = 1'b1;
                div_req.dividend = sqr_reg;
                state_next       = S_QDIV;
            end
            S_QDIV:
            begin
                if (!div_busy && !sqrt_busy)
                    state_next = S_RAD;
            end
            S_RAD:
            begin
                // a negative radicand drops the child from the contest
                if (rad_neg_reg)
                    state_next = S_FINISH;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.wide     = 1'b1;
                    div_req.dividend = DIV_W'(rad_reg);
                    state_next       = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (!div_busy)
                begin
                    sqrt_start = 1'b1;
                    sqrt_v     = div_quot[SQ_V_W-1:0];
                    state_next = S_RSQRT;
                end
            end
            S_RSQRT:
            begin
                if (!sqrt_busy)
                    state_next = S_SUM;
            end
            S_SUM:
                state_next = S_UPDATE;
            S_UPDATE:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (!item_reg.last_child)
                    state_next = S_IDLE;
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_mode_reg     <= 1'b0;
            explore_weight_reg <= CW'(92682);
            variance_bias_reg  <= '0;
        end
        else if (cfg_chan.valid)
        begin
            unique case (cfg_chan.data.index)
                CFG_SCORE_MODE:     score_mode_reg     <= cfg_chan.data.wdata[0];
                CFG_EXPLORE_WEIGHT: explore_weight_reg <= cfg_chan.data.wdata[CW-1:0];
                CFG_VARIANCE_BIAS:  variance_bias_reg  <= cfg_chan.data.wdata;
                default:            ;
            endcase
        end
    end

    // node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            win_score_reg   <= SCORE_MIN;
            best_index_reg  <= '0;
            have_winner_reg <= 1'b0;
            expand_err_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire && !in_chan.data.parent_expanded)
                expand_err_reg <= 1'b1;
            if (state_reg == S_CHECK && pos_reg < POS_W'(MAX_CHILDREN))
                pos_reg <= pos_reg + 1'b1;
            if (state_reg == S_UPDATE && score_reg > win_score_reg)
            begin
                win_score_reg   <= score_reg;
                best_index_reg  <= cur_idx_reg;
                have_winner_reg <= 1'b1;
            end
            if (emit)
            begin
                pos_reg         <= '0;
                win_score_reg   <= SCORE_MIN;
                best_index_reg  <= '0;
                have_winner_reg <= 1'b0;
                expand_err_reg  <= 1'b0;
            end
        end
    end

    // per-child datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_chan.data;
        unique case (state_reg)
            S_CHECK:
            begin
                cur_idx_reg <= IDX_W'(pos_reg);
                score_reg   <= SCORE_MAX;
            end
            S_MEAN:
                mean_reg <= r_neg ? -$signed({1'b0, div_quot[31:0]})
                                  : $signed({1'b0, div_quot[31:0]});
            S_TDIV:
            begin
                sqr_reg <= 64'(abs_r) * 64'(abs_r);
                var_reg <= '0;
            end
            S_TSQRT:
                explore_reg <= expl_prod[EXP_PW-1:FRAC_BITS];
            S_QDIV:
            begin
                explore_reg <= expl_prod[EXP_PW-1:FRAC_BITS];
                rad_neg_reg <= rad[64];
                rad_reg     <= rad[SQ_V_W-1:0];
            end
            S_RSQRT:
                var_reg <= sqrt_root;
            S_SUM:
                score_reg <= sum_sat;
            default:
                ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            rsp_reg.best_index <= '0;
            rsp_reg.win_score  <= '0;
            rsp_reg.status     <= STATUS_OK;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
            if (expand_err_reg)
            begin
                rsp_reg.best_index <= '0;
                rsp_reg.win_score  <= '0;
                rsp_reg.status     <= STATUS_NOT_EXPANDED;
            end
            else if (!have_winner_reg)
            begin
                rsp_reg.best_index <= '0;
                rsp_reg.win_score  <= '0;
                rsp_reg.status     <= STATUS_NO_WINNER;
            end
            else
            begin
                rsp_reg.best_index <= best_index_reg;
                rsp_reg.win_score  <= win_score_reg;
                rsp_reg.status     <= STATUS_OK;
            end
        end
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    assign in_chan.ready  = (state_reg == S_IDLE);
    assign cfg_chan.ready = 1'b1;
    assign out_chan.valid = out_valid_reg;
    assign out_chan.data  = rsp_reg;

endmodule

FILE: tb/ucbcs_select_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbcs_select_checker
// Watches the child, result and register channels of the UCB child selector,
// computes the winner of each node on its own and compares every result
// field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ucbcs_select_checker (
    input  logic  clk,
    input  logic  rst_n,
    ucbcs_chan_if child_mon,
    ucbcs_chan_if result_mon,
    ucbcs_chan_if cfg_mon,
    output int    mismatches,
    output int    pending,
    output int    results_seen
);
    import ucbcs_pkg::*;

    localparam int F = FRAC_BITS_DEF;

    logic        mode_sp;
    logic [23:0] weight_c;
    logic [31:0] bias_d;

    int          node_pos;
    longint      lead_score;
    logic [7:0]  lead_index;
    logic        lead_valid;
    logic        expand_bad;

    select_rsp_t winners_q[$];

    // floor(sqrt(v * 2^F)), one result bit per step
    function automatic logic [63:0] root_scaled(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [1:0]  pair;
        int          p;
        root = 0;
        rem  = 0;
        for (int i = 39; i >= 0; i--)
        begin
            for (int b = 0; b < 2; b++)
            begin
                p = 2 * i + 1 - b;
                pair[1 - b] = (p >= F && p - F < 64) ? v[p - F] : 1'b0;
            end
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // natural log in Q.F through log2 by repeated squaring
    function automatic logic [63:0] ln_fixed(input logic [63:0] x);
        int          k;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l2;
        k    = 0;
        frac = 0;
        while (k < 63 && (x >> (k + 1)) != 0)
            k++;
        m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
        for (int i = 0; i < F; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l2 = (64'(k) << F) | frac;
        return (l2 * {32'd0, LN2_Q32}) >> 32;
    endfunction

    function automatic void score_child(input child_req_t c, output longint sc,
                                        output bit ok);
        longint      r;
        longint      n_s;
        logic [63:0] t;
        logic [63:0] ar;
        logic [63:0] q;
        longint      rad;
        ok = 1;
        if (c.child_visits == 0)
        begin
            sc = SCORE_MAX;
            return;
        end
        r   = c.child_reward;
        n_s = {32'd0, c.child_visits};
        t   = (64'd2 * ln_fixed({32'd0, c.parent_visits} + 64'd1)) / n_s;
        sc  = r / n_s + longint'(({40'd0, weight_c} * root_scaled(t)) >> F);
        if (mode_sp)
        begin
            ar  = (r < 0) ? -r : r;
            q   = ((ar * ar) / n_s) >> F;
            rad = longint'({16'd0, c.child_sq_reward} + {32'd0, bias_d}) - longint'(q);
            if (rad < 0)
                ok = 0;
            else
                sc = sc + longint'(root_scaled(rad / n_s));
        end
        if (sc > longint'(SCORE_MAX))
            sc = SCORE_MAX;
        else if (sc < longint'(SCORE_MIN))
            sc = SCORE_MIN;
    endfunction

    task automatic clear_node();
        node_pos   = 0;
        lead_score = SCORE_MIN;
        lead_index = 0;
        lead_valid = 0;
        expand_bad = 0;
    endtask

    assign pending = winners_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        child_req_t  c;
        select_rsp_t want;
        select_rsp_t got;
        longint      sc;
        bit          ok;
        if (!rst_n)
        begin
            mode_sp      = 0;
            weight_c     = 24'd92682;
            bias_d       = 0;
            mismatches   = 0;
            results_seen = 0;
            winners_q.delete();
            clear_node();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.data.index)
                    CFG_SCORE_MODE:     mode_sp  = cfg_mon.data.wdata[0];
                    CFG_EXPLORE_WEIGHT: weight_c = cfg_mon.data.wdata[23:0];
                    CFG_VARIANCE_BIAS:  bias_d   = cfg_mon.data.wdata;
                    default: ;
                endcase
            end
            if (child_mon.valid && child_mon.ready)
            begin
                c = child_mon.data;
                if (!c.parent_expanded)
                    expand_bad = 1;
                if (node_pos < MAX_CHILDREN_DEF)
                begin
                    score_child(c, sc, ok);
                    if (ok && sc > lead_score)
                    begin
                        lead_score = sc;
                        lead_index = node_pos[7:0];
                        lead_valid = 1;
                    end
                    node_pos++;
                end
                if (c.last_child)
                begin
                    if (expand_bad)
                        want = '{0, 0, STATUS_NOT_EXPANDED};
                    else if (!lead_valid)
                        want = '{0, 0, STATUS_NO_WINNER};
                    else
                        want = '{lead_index, lead_score[47:0], STATUS_OK};
                    winners_q.push_back(want);
                    clear_node();
                end
            end
            if (result_mon.valid && result_mon.ready)
            begin
                got = result_mon.data;
                results_seen++;
                if (winners_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result idx=%0d score=%0d status=%0d",
                                 $realtime, got.best_index, got.win_score, got.status);
                end
                else
                begin
                    want = winners_q.pop_front();
                    if (got.best_index !== want.best_index ||
                        got.win_score !== want.win_score || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result %0d: expected idx=%0d score=%0d st=%0d",
                                     $realtime, results_seen, want.best_index,
                                     want.win_score, want.status,
                                     ", got idx=%0d score=%0d st=%0d",
                                     got.best_index, got.win_score, got.status);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_ucb_child_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ucb_child_selector
// Drives nodes of children through the UCB child selector under several
// register settings and handshake pressures; a checker judges the results.
// ----------------------------------------------------------------------------
module tb_ucb_child_selector;
    import ucbcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    logic clk;
    logic rst_n;

    ucbcs_chan_if #(.T(child_req_t))  in_chan ();
    ucbcs_chan_if #(.T(select_rsp_t)) out_chan ();
    ucbcs_chan_if #(.T(cfg_req_t))    cfg_chan ();

    int  mismatches;
    int  pending;
    int  results_seen;
    int  items_sent;
    int  idle_pct;
    int  stall_pct;
    int  holds_wanted;
    int  holds_done;
    int  quiet_cycles;
    logic child_taken;
    logic cfg_taken;

    ucb_child_selector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .cfg_chan (cfg_chan)
    );

    ucbcs_select_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .child_mon    (in_chan),
        .result_mon   (out_chan),
        .cfg_mon      (cfg_chan),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        child_taken <= in_chan.valid && in_chan.ready;
        cfg_taken   <= cfg_chan.valid && cfg_chan.ready;
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
            (cfg_chan.valid && cfg_chan.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls plus the occasional long hold-off
    initial
    begin
        out_chan.ready = 0;
        holds_done     = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_wanted)
            begin
                holds_done++;
                out_chan.ready <= 0;
                repeat (3000) @(negedge clk);
            end
            out_chan.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_chan.valid = 1;
        cfg_chan.data  = '{idx, val};
        do @(negedge clk); while (!cfg_taken);
        cfg_chan.valid = 0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic mode, input logic [23:0] c,
                                 input logic [31:0] d);
        wait_drained();
        write_reg(CFG_SCORE_MODE, {31'd0, mode});
        write_reg(CFG_EXPLORE_WEIGHT, {8'd0, c});
        write_reg(CFG_VARIANCE_BIAS, d);
    endtask

    task automatic send_child(input logic [31:0] pv, input logic pe, input logic [31:0] n,
                              input logic [31:0] r, input logic [47:0] sq,
                              input logic last);
        if (idle_pct > 0)
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        in_chan.valid = 1;
        in_chan.data  = '{pv, pe, n, r, sq, last};
        do @(negedge clk); while (!child_taken);
        in_chan.valid = 0;
        items_sent++;
    endtask

    task automatic random_node(input int len);
        logic [31:0] pv;
        logic [31:0] n;
        logic [31:0] r;
        logic [63:0] ar;
        logic [63:0] sq;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(3))
                0:       pv = $urandom_range(0, 20);
                1:       pv = 32'hFFFF_FFFF;
                default: pv = $urandom;
            endcase
            case ($urandom_range(9))
                0:       n = 0;
                9:       n = 32'hFFFF_FFFF;
                6, 7, 8: n = $urandom;
                default: n = $urandom_range(1, 1000);
            endcase
            r = ($urandom_range(1)) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
            case ($urandom_range(3))
                0:       sq = {$urandom, $urandom};
                1:       sq = $urandom_range(0, 65536);
                default:
                begin
                    // keep the variance radicand non-negative most of the time
                    ar = r[31] ? -{{32{1'b1}}, r} : {32'd0, r};
                    sq = (n == 0) ? 64'd0 : ((ar * ar) / n) >> 16;
                    sq = sq + $urandom_range(0, 1 << 20);
                end
            endcase
            send_child(pv, ($urandom_range(39) != 0), n, r, sq[47:0], i == len - 1);
        end
    endtask

    task automatic random_phase(input int count);
        int len;
        while (count > 0)
        begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            count -= len;
            random_node(len);
        end
    endtask

    initial
    begin
        logic [23:0] cw_tab[6];
        logic [31:0] d_tab[6];
        logic        m_tab[6];
        rst_n          = 0;
        in_chan.valid  = 0;
        in_chan.data   = '0;
        cfg_chan.valid = 0;
        cfg_chan.data  = '0;
        items_sent     = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        holds_wanted   = 0;
        quiet_cycles   = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: plain score at reset configuration
        send_child(100, 1, 10, 5 << 16, 0, 0);
        send_child(100, 1, 0, 0, 0, 0);                  // zero visits wins
        send_child(100, 1, 10, 5 << 16, 0, 1);
        send_child(50, 1, 4, 1 << 16, 0, 0);              // tie keeps the earlier child
        send_child(50, 1, 4, 1 << 16, 0, 1);
        send_child(7, 0, 3, 2 << 16, 0, 0);               // parent not expanded
        send_child(7, 1, 3, 2 << 16, 0, 1);
        send_child(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1);
        send_child(0, 1, 1, 32'h7FFF_FFFF, 0, 1);
        send_child(32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 48'h8000_0000_0000, 1);

        // directed: variance term, negative radicand and no winner
        apply_setting(1, 24'd92682, 32'd0);
        send_child(10, 1, 1, 32'h7FFF_FFFF, 0, 1);
        send_child(10, 1, 2, 1 << 16, 1 << 16, 0);
        send_child(10, 1, 1, 32'h8000_0000, 0, 1);
        send_child(10, 1, 5, 3 << 16, 48'hFFFF_FFFF_FFFF, 1);

        m_tab  = '{0, 1, 1, 0, 1, 0};
        cw_tab = '{24'd92682, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 24'd40000, 24'd0};
        d_tab  = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd12345, 32'd0, 32'hFFFF_FFFF};
        for (int s = 0; s < 6; s++)
        begin
            apply_setting(m_tab[s], cw_tab[s], (s == 4) ? $urandom : d_tab[s]);
            idle_pct = 0;  stall_pct = 0;  random_phase(50);
            if (s == 1)
                holds_wanted = 1;                         // receiver backs off, input fills
            idle_pct = 70; stall_pct = 0;  random_phase(50);
            if (s == 2)
                while (pending != 0)
                    @(negedge clk);
            idle_pct = 0;  stall_pct = 70; random_phase(50);
            idle_pct = 18; stall_pct = 18; random_phase(50);
            if (s == 3)
            begin
                idle_pct = 0; stall_pct = 0;
                random_node(262);                         // overflows the child limit
            end
        end

        wait_drained();
        $display("Sent %0d children, checked %0d results over six register settings",
                 items_sent, results_seen);
        $display("and four handshake pressure profiles, including a child-limit overflow.");
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
